FILE: hw/rtl/eprk_pkg.sv
package eprk_pkg;

	localparam int SLOTS   = 16;
	localparam int PIECE_W = 4;
	localparam int LOCS    = 12;
	localparam int LOC_W   = 48;
	localparam int FLAG_W  = 12;
	localparam int RANK_W  = 40;

	typedef logic [PIECE_W-1:0] piece_t;

	typedef struct packed {
		piece_t [SLOTS-1:0] perm;
		piece_t [SLOTS-1:0] inv;
		logic [RANK_W-1:0]  acc;
	} eprk_item_t;

	// product of lo+1 .. hi, wrapping at 64 bits
	function automatic logic [63:0] fact_span(input int hi, input int lo);
		logic [63:0] f;
		f = 64'd1;
		for (int k = 2; k <= SLOTS; k++) begin
			if (k > lo && k <= hi) begin
				f = f * 64'(k);
			end
		end
		return f;
	endfunction

endpackage

FILE: hw/rtl/eprk_cell.sv
module eprk_cell #(
	parameter int PIECES = 12,
	parameter int STEP   = 12
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   advance,
	input  logic                   valid_in,
	input  eprk_pkg::eprk_item_t   item_in,
	output logic                   valid_out,
	output eprk_pkg::eprk_item_t   item_out
);

	localparam eprk_pkg::piece_t TOP = eprk_pkg::PIECE_W'(STEP - 1);
	localparam logic [eprk_pkg::RANK_W-1:0] WEIGHT =
		eprk_pkg::RANK_W'(eprk_pkg::fact_span(PIECES, STEP));

	eprk_pkg::eprk_item_t nxt;
	eprk_pkg::piece_t     s;
	eprk_pkg::piece_t     j;
	logic                 valid_q;
	eprk_pkg::eprk_item_t item_q;

	always_comb begin
		s = item_in.perm[TOP];
		j = item_in.inv[TOP];
		nxt = item_in;
		nxt.perm[TOP] = item_in.perm[j];
		nxt.perm[j]   = item_in.perm[TOP];
		nxt.inv[s]    = item_in.inv[TOP];
		nxt.inv[TOP]  = item_in.inv[s];
		nxt.acc = item_in.acc +
			({{(eprk_pkg::RANK_W-eprk_pkg::PIECE_W){1'b0}}, s} * WEIGHT);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (advance) begin
			valid_q <= valid_in;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			item_q <= nxt;
		end
	end

	assign valid_out = valid_q;
	assign item_out  = item_q;

endmodule

FILE: hw/rtl/edge_permutation_orientation_rank_core.sv
// Pipeline: one load stage, then one cell per ranking step, the last cell being the
// output register.
// Throughput: one item per cycle; the whole chain holds while the output item waits.
// Reset: asynchronous, active low; clears the valid bit of every stage, payload is not reset.
module edge_permutation_orientation_rank_core #(
	parameter int PIECES = 12
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [47:0] piece_at_location,
	input  logic [11:0] piece_flipped,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [39:0] state_rank
);

	localparam int CELLS = PIECES - 1;
	localparam logic [eprk_pkg::SLOTS-2:0] OMASK =
		(eprk_pkg::SLOTS-1)'((64'd1 << (PIECES - 1)) - 64'd1);
	localparam logic [eprk_pkg::RANK_W-1:0] FACT =
		eprk_pkg::RANK_W'(eprk_pkg::fact_span(PIECES, 1));

	logic                          advance;
	logic                          valid_c [CELLS:0];
	eprk_pkg::eprk_item_t          item_c  [CELLS:0];
	eprk_pkg::eprk_item_t          load;
	logic [eprk_pkg::SLOTS-2:0]    orient;
	logic                          load_valid_q;
	eprk_pkg::eprk_item_t          load_q;

	assign advance  = !valid_c[CELLS] || out_ready;
	assign in_ready = advance;

	always_comb begin
		load = '0;
		for (int x = 0; x < eprk_pkg::LOCS; x++) begin
			if (x < PIECES) begin
				load.perm[x] = piece_at_location[4*x +: 4];
			end
		end
		for (int x = 0; x < eprk_pkg::SLOTS; x++) begin
			if (x < PIECES) begin
				load.inv[load.perm[x]] = eprk_pkg::PIECE_W'(x);
			end
		end
		orient = {{(eprk_pkg::SLOTS-eprk_pkg::FLAG_W){1'b0}}, piece_flipped[11:1]} & OMASK;
		load.acc = {{(eprk_pkg::RANK_W-eprk_pkg::SLOTS+1){1'b0}}, orient} * FACT;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			load_valid_q <= 1'b0;
		end else if (advance) begin
			load_valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			load_q <= load;
		end
	end

	assign valid_c[0] = load_valid_q;
	assign item_c[0]  = load_q;

	for (genvar c = 0; c < CELLS; c++) begin : g_cell
		eprk_cell #(
			.PIECES (PIECES),
			.STEP   (PIECES - c)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.advance   (advance),
			.valid_in  (valid_c[c]),
			.item_in   (item_c[c]),
			.valid_out (valid_c[c+1]),
			.item_out  (item_c[c+1])
		);
	end

	assign out_valid  = valid_c[CELLS];
	assign state_rank = item_c[CELLS].acc;

endmodule
